### sv/wall_collision_tracker_core_defines.svh
// Assertion macros used by the checker file of the collision tracker.
`ifndef WALL_COLLISION_TRACKER_CORE_DEFINES_SVH
`define WALL_COLLISION_TRACKER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WCT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("collision tracker check failed");

// Next-cycle implication, disabled while reset is asserted.
`define WCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("collision tracker check failed");

`endif

### sv/wct_pkg.sv
// Package of the collision tracker: sizes, codes and shared types.
package wct_pkg;

    localparam int NUM_MOLECULES = 4096;
    localparam int MOL_AW        = $clog2(NUM_MOLECULES);

    localparam logic [15:0] MCNT_MAX = 16'hFFFF;
    localparam logic [31:0] TCNT_MAX = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        CFG_WALL_CUTOFF     = 2'd0,
        CFG_CHANNEL_HEIGHT  = 2'd1,
        CFG_TRACKED_SPECIES = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_EMIT_ENTRY,
        ST_EMIT_EXIT
    } t_state;

    typedef struct packed {
        logic [31:0]        frame;
        logic [19:0]        px;
        logic [19:0]        py;
        logic [19:0]        pz;
        logic signed [19:0] vx;
        logic signed [19:0] vy;
        logic signed [19:0] vz;
    } t_sample;

    localparam int SAMPLE_W = $bits(t_sample);

    typedef struct packed {
        logic        in_mid;
        logic        open;
        logic [15:0] count;
    } t_mol_status;

    localparam int STATUS_W = $bits(t_mol_status);

    typedef struct packed {
        logic [11:0] molecule;
        t_sample     smp;
        logic        is_exit;
        logic        wall_side;
        logic [15:0] mcount;
        logic [31:0] tcount;
    } t_record;

    typedef struct packed {
        logic clr_step;
        logic capture;
        logic eval;
        logic sel_exit;
    } t_ctrl_cmd;

    typedef struct packed {
        logic clr_done;
        logic emit;
    } t_dp_status;

endpackage

### sv/wct_sample_if.sv
// Handshake channel that carries one molecule sample per item.
interface wct_sample_if;
    logic               valid;
    logic               ready;
    logic [11:0]        molecule_index;
    logic [31:0]        frame_number;
    logic               first_frame;
    logic [7:0]         species;
    logic [19:0]        pos_x;
    logic [19:0]        pos_y;
    logic [19:0]        pos_z;
    logic signed [19:0] vel_x;
    logic signed [19:0] vel_y;
    logic signed [19:0] vel_z;

    modport source (
        output valid, molecule_index, frame_number, first_frame, species,
               pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
        input  ready
    );

    modport sink (
        input  valid, molecule_index, frame_number, first_frame, species,
               pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
        output ready
    );
endinterface

### sv/wct_record_if.sv
// Handshake channel that carries one collision record per item.
interface wct_record_if;
    logic               valid;
    logic               ready;
    logic [11:0]        record_molecule;
    logic [31:0]        record_frame;
    logic [19:0]        record_x;
    logic [19:0]        record_y;
    logic [19:0]        record_z;
    logic signed [19:0] record_vx;
    logic signed [19:0] record_vy;
    logic signed [19:0] record_vz;
    logic               is_exit_record;
    logic               wall_side;
    logic [15:0]        molecule_collision_count;
    logic [31:0]        total_collision_count;

    modport source (
        output valid, record_molecule, record_frame, record_x, record_y, record_z,
               record_vx, record_vy, record_vz, is_exit_record, wall_side,
               molecule_collision_count, total_collision_count,
        input  ready
    );

    modport sink (
        input  valid, record_molecule, record_frame, record_x, record_y, record_z,
               record_vx, record_vy, record_vz, is_exit_record, wall_side,
               molecule_collision_count, total_collision_count,
        output ready
    );
endinterface

### sv/wall_collision_tracker_core.sv
// Top level of the collision tracker: sequencer, datapath and channel ports.
// When an item yields no record, the next one can be taken after the read and evaluate
// states. An item that closes a collision yields its entry record after those states
// and its exit record once the entry record is taken; the output may stall either one.
// The pace is set by one read-modify-write of the per-molecule tables per item.
// After reset a clearing pass zeroes all 4096 entries of the molecule status table;
// no item is taken during it, configuration writes are taken in every sequencer state.
module wall_collision_tracker_core
    import wct_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [19:0]   i_cfg_data,
    wct_sample_if.sink    i_sample,
    wct_record_if.source  o_record
);
    t_ctrl_cmd  cmd;
    t_dp_status sts;
    t_sample    in_smp;
    t_record    rec;

    assign in_smp.frame = i_sample.frame_number;
    assign in_smp.px    = i_sample.pos_x;
    assign in_smp.py    = i_sample.pos_y;
    assign in_smp.pz    = i_sample.pos_z;
    assign in_smp.vx    = i_sample.vel_x;
    assign in_smp.vy    = i_sample.vel_y;
    assign in_smp.vz    = i_sample.vel_z;

    wct_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_sample.valid),
        .o_in_ready  (i_sample.ready),
        .o_out_valid (o_record.valid),
        .i_out_ready (o_record.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    wct_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_molecule_index (i_sample.molecule_index),
        .i_first_frame    (i_sample.first_frame),
        .i_species        (i_sample.species),
        .i_sample         (in_smp),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_record         (rec)
    );

    assign o_record.record_molecule          = rec.molecule;
    assign o_record.record_frame             = rec.smp.frame;
    assign o_record.record_x                 = rec.smp.px;
    assign o_record.record_y                 = rec.smp.py;
    assign o_record.record_z                 = rec.smp.pz;
    assign o_record.record_vx                = rec.smp.vx;
    assign o_record.record_vy                = rec.smp.vy;
    assign o_record.record_vz                = rec.smp.vz;
    assign o_record.is_exit_record           = rec.is_exit;
    assign o_record.wall_side                = rec.wall_side;
    assign o_record.molecule_collision_count = rec.mcount;
    assign o_record.total_collision_count    = rec.tcount;
endmodule

### sv/wct_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### sv/wct_ctrl.sv
// Sequencer of the collision tracker: table clear, sample evaluation, record output.
module wct_ctrl
    import wct_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_ctrl_cmd  o_cmd,
    input  t_dp_status i_sts
);
    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_sts.clr_done) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_READ;
            end
            ST_READ: begin
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                n_state = i_sts.emit ? ST_EMIT_ENTRY : ST_IDLE;
            end
            ST_EMIT_ENTRY: begin
                if (i_out_ready) n_state = ST_EMIT_EXIT;
            end
            ST_EMIT_EXIT: begin
                if (i_out_ready) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
            end
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            ST_EVAL: begin
                o_cmd.eval = 1'b1;
            end
            ST_EMIT_ENTRY: begin
                o_out_valid = 1'b1;
            end
            ST_EMIT_EXIT: begin
                o_out_valid    = 1'b1;
                o_cmd.sel_exit = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end
endmodule

### sv/wct_datapath.sv
// Datapath of the collision tracker: configuration, molecule tables, counters, records.
module wct_datapath
    import wct_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [19:0]        i_cfg_data,
    input  logic [11:0]        i_molecule_index,
    input  logic               i_first_frame,
    input  logic [7:0]         i_species,
    input  t_sample            i_sample,
    input  t_ctrl_cmd          i_cmd,
    output t_dp_status         o_sts,
    output t_record            o_record
);
    logic [19:0] r_cut;
    logic [19:0] r_height;
    logic [7:0]  r_trk;

    logic [11:0] r_mol;
    logic        r_first;
    logic [7:0]  r_species;
    t_sample     r_cur;
    t_sample     r_ent;
    logic        r_side;
    logic [15:0] r_mcnt;
    logic [31:0] r_total;
    logic [MOL_AW-1:0] r_clr_cnt;

    logic [STATUS_W-1:0] st_rd_raw;
    logic [SAMPLE_W-1:0] last_rd_raw;
    logic [SAMPLE_W-1:0] ent_rd_raw;
    t_mol_status st_rd;
    t_sample     last_rd;
    t_sample     ent_rd;

    logic [MOL_AW-1:0] mol_addr;
    logic              item_ok;
    logic [20:0]       z_plus_cut;
    logic              middle;
    logic [20:0]       z_sum;
    logic              side;
    t_mol_status       n_st;
    logic [31:0]       n_total;
    logic              emit;
    logic              ent_we;
    logic              tab_we;
    logic              st_we;
    logic [MOL_AW-1:0] st_waddr;
    t_mol_status       st_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cut    <= 20'd15360;
            r_height <= 20'd102400;
            r_trk    <= 8'd1;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_WALL_CUTOFF:     r_cut    <= i_cfg_data;
                CFG_CHANNEL_HEIGHT:  r_height <= i_cfg_data;
                CFG_TRACKED_SPECIES: r_trk    <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mol     <= i_molecule_index;
            r_first   <= i_first_frame;
            r_species <= i_species;
            r_cur     <= i_sample;
        end
    end

    assign mol_addr = MOL_AW'(r_mol);
    assign st_rd    = t_mol_status'(st_rd_raw);
    assign last_rd  = t_sample'(last_rd_raw);
    assign ent_rd   = t_sample'(ent_rd_raw);

    assign item_ok    = (r_species == r_trk) && (32'(r_mol) < 32'(NUM_MOLECULES));
    assign z_plus_cut = {1'b0, r_cur.pz} + {1'b0, r_cut};
    assign middle     = (r_cur.pz >= r_cut) && (z_plus_cut <= {1'b0, r_height});
    assign z_sum      = {1'b0, ent_rd.pz} + {1'b0, r_cur.pz};
    assign side       = z_sum >= {1'b0, r_height};

    always_comb begin
        n_st    = st_rd;
        n_total = r_total;
        emit    = 1'b0;
        ent_we  = 1'b0;
        if (r_first) begin
            n_st.in_mid = middle;
        end else if (!middle) begin
            if (st_rd.in_mid) begin
                n_st.open = 1'b1;
                ent_we    = 1'b1;
            end
            n_st.in_mid = 1'b0;
        end else begin
            if (st_rd.open) begin
                emit      = 1'b1;
                n_st.open = 1'b0;
                if (st_rd.count != MCNT_MAX) n_st.count = st_rd.count + 16'd1;
                if (r_total != TCNT_MAX) n_total = r_total + 32'd1;
            end
            n_st.in_mid = 1'b1;
        end
    end

    assign tab_we   = i_cmd.eval && item_ok;
    assign st_we    = i_cmd.clr_step || tab_we;
    assign st_waddr = i_cmd.clr_step ? r_clr_cnt : mol_addr;
    assign st_wdata = i_cmd.clr_step ? t_mol_status'('0) : n_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total   <= '0;
            r_clr_cnt <= '0;
        end else begin
            if (i_cmd.clr_step) r_clr_cnt <= r_clr_cnt + MOL_AW'(1);
            if (tab_we && emit) r_total <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tab_we && emit) begin
            r_ent  <= ent_rd;
            r_side <= side;
            r_mcnt <= n_st.count;
        end
    end

    wct_ram #(.WIDTH(STATUS_W), .DEPTH(NUM_MOLECULES)) u_status_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (mol_addr),
        .o_rdata (st_rd_raw)
    );

    wct_ram #(.WIDTH(SAMPLE_W), .DEPTH(NUM_MOLECULES)) u_last_ram (
        .i_clk   (i_clk),
        .i_we    (tab_we),
        .i_waddr (mol_addr),
        .i_wdata (r_cur),
        .i_raddr (mol_addr),
        .o_rdata (last_rd_raw)
    );

    wct_ram #(.WIDTH(SAMPLE_W), .DEPTH(NUM_MOLECULES)) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (tab_we && ent_we),
        .i_waddr (mol_addr),
        .i_wdata (last_rd),
        .i_raddr (mol_addr),
        .o_rdata (ent_rd_raw)
    );

    assign o_sts.clr_done = r_clr_cnt == MOL_AW'(NUM_MOLECULES - 1);
    assign o_sts.emit     = item_ok && emit;

    assign o_record.molecule  = r_mol;
    assign o_record.smp       = i_cmd.sel_exit ? r_cur : r_ent;
    assign o_record.is_exit   = i_cmd.sel_exit;
    assign o_record.wall_side = r_side;
    assign o_record.mcount    = r_mcnt;
    assign o_record.tcount    = r_total;
endmodule

### sv/wct_checker.sv
// Port-level checks of the collision tracker and their binding to the top level.
`include "wall_collision_tracker_core_defines.svh"

module wct_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_out_is_exit,
    input logic        i_out_side,
    input logic [15:0] i_out_mcount,
    input logic [31:0] i_out_tcount
);
    `WCT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_is_exit) && $stable(i_out_tcount))
    `WCT_ASSERT_NEXT(a_exit_follows_entry, i_clk, i_rst_n, i_out_valid && i_out_ready && !i_out_is_exit, i_out_valid && i_out_is_exit && $stable(i_out_side) && $stable(i_out_mcount) && $stable(i_out_tcount))
    `WCT_ASSERT_NOW(a_no_accept_while_output, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_out_valid)
    `WCT_ASSERT_NOW(a_counts_nonzero, i_clk, i_rst_n, i_out_valid, (i_out_mcount != 16'd0) && (i_out_tcount != 32'd0))
endmodule

bind wall_collision_tracker_core wct_checker u_wct_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_sample.valid),
    .i_in_ready    (i_sample.ready),
    .i_out_valid   (o_record.valid),
    .i_out_ready   (o_record.ready),
    .i_out_is_exit (o_record.is_exit_record),
    .i_out_side    (o_record.wall_side),
    .i_out_mcount  (o_record.molecule_collision_count),
    .i_out_tcount  (o_record.total_collision_count)
);

### sim/tb_wall_collision_tracker_core.sv
// Self-checking testbench of the wall collision tracker: directed and random sample streams, predicted records.
module tb_wall_collision_tracker_core;
    import wct_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic [11:0] mol;
        logic        first;
        logic [7:0]  species;
        t_sample     smp;
    } t_mol_sample;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [19:0] i_cfg_data;

    wct_sample_if smp_ch ();
    wct_record_if rec_ch ();

    wall_collision_tracker_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_sample   (smp_ch),
        .o_record   (rec_ch)
    );

    logic [19:0] cutoff_cfg  = 20'd15360;
    logic [19:0] height_cfg  = 20'd102400;
    logic [7:0]  species_cfg = 8'd1;

    bit          mid_flag   [NUM_MOLECULES];
    bit          open_flag  [NUM_MOLECULES];
    bit   [15:0] mol_count  [NUM_MOLECULES];
    bit   [31:0] total_count;
    t_sample     last_smp   [NUM_MOLECULES];
    t_sample     entry_smp  [NUM_MOLECULES];

    t_mol_sample samples_to_send [$];
    t_record     collision_records_due [$];
    t_mol_sample next_sample;

    int samples_queued = 0;
    int samples_taken  = 0;
    int mismatches     = 0;
    int src_idle_pct   = 20;
    int snk_idle_pct   = 20;
    int src_gap;
    int snk_gap;
    int quiet_cycles;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic bit in_band(longint z);
        return (z >= longint'(cutoff_cfg)) &&
               (z + longint'(cutoff_cfg) <= longint'(height_cfg));
    endfunction

    function automatic void track_sample(t_mol_sample it);
        logic [11:0] m;
        t_record     r;
        m = it.mol;
        if (it.species != species_cfg) return;
        if (it.first) begin
            mid_flag[m] = in_band(longint'(it.smp.pz));
        end else if (!in_band(longint'(it.smp.pz))) begin
            if (mid_flag[m]) begin
                open_flag[m] = 1'b1;
                entry_smp[m] = last_smp[m];
            end
            mid_flag[m] = 1'b0;
        end else begin
            if (open_flag[m]) begin
                if (mol_count[m] != MCNT_MAX) mol_count[m]++;
                if (total_count != TCNT_MAX) total_count++;
                r.molecule  = m;
                r.smp       = entry_smp[m];
                r.is_exit   = 1'b0;
                r.wall_side = (longint'(entry_smp[m].pz) + longint'(it.smp.pz) >=
                               longint'(height_cfg));
                r.mcount    = mol_count[m];
                r.tcount    = total_count;
                collision_records_due = {collision_records_due, r};
                r.smp     = it.smp;
                r.is_exit = 1'b1;
                collision_records_due = {collision_records_due, r};
                open_flag[m] = 1'b0;
            end
            mid_flag[m] = 1'b1;
        end
        last_smp[m] = it.smp;
    endfunction

    function automatic string rec_text(t_record r);
        return $sformatf(
            "mol %0d frame %0d pos %0d/%0d/%0d vel %0d/%0d/%0d exit %0b side %0b cnt %0d/%0d",
            r.molecule, r.smp.frame, r.smp.px, r.smp.py, r.smp.pz,
            $signed(r.smp.vx), $signed(r.smp.vy), $signed(r.smp.vz),
            r.is_exit, r.wall_side, r.mcount, r.tcount);
    endfunction

    function automatic void queue_sample(logic [11:0] mol, logic [31:0] frame, bit first,
                                         logic [7:0] spc, logic [19:0] pz, logic [19:0] px,
                                         logic [19:0] py, logic [19:0] vx, logic [19:0] vy,
                                         logic [19:0] vz);
        t_mol_sample s;
        s.mol       = mol;
        s.first     = first;
        s.species   = spc;
        s.smp.frame = frame;
        s.smp.px    = px;
        s.smp.py    = py;
        s.smp.pz    = pz;
        s.smp.vx    = vx;
        s.smp.vy    = vy;
        s.smp.vz    = vz;
        samples_to_send = {samples_to_send, s};
        samples_queued++;
    endfunction

    function automatic void queue_motion(logic [11:0] mol, logic [31:0] frame, bit first,
                                         logic [7:0] spc, logic [19:0] pz);
        queue_sample(mol, frame, first, spc, pz, 20'($urandom), 20'($urandom),
                     20'($urandom), 20'($urandom), 20'($urandom));
    endfunction

    // Favors the band edges so that both boundary comparisons are exercised.
    function automatic logic [19:0] pick_z(bit want_mid);
        longint c;
        longint h;
        longint cand;
        int     k;
        c    = longint'(cutoff_cfg);
        h    = longint'(height_cfg);
        cand = 0;
        for (k = 0; k < 32; k++) begin
            case ($urandom_range(0, 7))
                0: cand = c;
                1: cand = c - 1;
                2: cand = h - c;
                3: cand = h - c + 1;
                4: cand = longint'($urandom_range(0, 1048575));
                default: cand = longint'($urandom_range(0, 32'((h > 0) ? h : 1)));
            endcase
            if (cand < 0) cand = 0;
            if (cand > 1048575) cand = 1048575;
            if (in_band(cand) == want_mid) return cand[19:0];
        end
        return cand[19:0];
    endfunction

    task automatic write_reg(t_cfg_idx idx, logic [19:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_WALL_CUTOFF:     cutoff_cfg  = val;
            CFG_CHANNEL_HEIGHT:  height_cfg  = val;
            CFG_TRACKED_SPECIES: species_cfg = val[7:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [19:0] c, logic [19:0] h, logic [7:0] spc);
        write_reg(CFG_WALL_CUTOFF, c);
        write_reg(CFG_CHANNEL_HEIGHT, h);
        write_reg(CFG_TRACKED_SPECIES, {12'd0, spc});
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain_and_settle();
        while (samples_taken != samples_queued || collision_records_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_random_phase(int n_items);
        logic [11:0] pool_mol   [6];
        logic [31:0] pool_frame [6];
        bit          pool_mid   [6];
        int          k;
        int          m;
        int          r;
        for (k = 0; k < 6; k++) begin
            pool_mol[k]   = 12'($urandom_range(0, 4095));
            pool_frame[k] = $urandom;
            pool_mid[k]   = 1'($urandom_range(0, 1));
            queue_motion(pool_mol[k], pool_frame[k], 1'b1, species_cfg, pick_z(pool_mid[k]));
        end
        for (k = 0; k < n_items; k++) begin
            m = int'($urandom_range(0, 5));
            r = int'($urandom_range(0, 99));
            pool_frame[m]++;
            if (r < 85) begin
                if ($urandom_range(0, 9) < 6) pool_mid[m] = !pool_mid[m];
                queue_motion(pool_mol[m], pool_frame[m], 1'b0, species_cfg,
                             pick_z(pool_mid[m]));
            end else if (r < 92) begin
                queue_motion(pool_mol[m], pool_frame[m], 1'b0,
                             species_cfg ^ 8'($urandom_range(1, 255)), 20'($urandom));
            end else if (r < 96) begin
                queue_motion(pool_mol[m], pool_frame[m], 1'b1, species_cfg, 20'($urandom));
            end else begin
                queue_motion(12'($urandom), $urandom, 1'($urandom_range(0, 1)), species_cfg,
                             20'($urandom));
            end
        end
        drain_and_settle();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            smp_ch.valid <= 1'b0;
            src_gap      <= 0;
        end else if (!smp_ch.valid || smp_ch.ready) begin
            if (src_gap != 0) begin
                smp_ch.valid <= 1'b0;
                src_gap      <= src_gap - 1;
            end else if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
                smp_ch.valid <= 1'b0;
                src_gap      <= int'($urandom_range(0, 3));
            end else if (samples_to_send.size() != 0) begin
                next_sample = samples_to_send.pop_front();
                smp_ch.valid          <= 1'b1;
                smp_ch.molecule_index <= next_sample.mol;
                smp_ch.frame_number   <= next_sample.smp.frame;
                smp_ch.first_frame    <= next_sample.first;
                smp_ch.species        <= next_sample.species;
                smp_ch.pos_x          <= next_sample.smp.px;
                smp_ch.pos_y          <= next_sample.smp.py;
                smp_ch.pos_z          <= next_sample.smp.pz;
                smp_ch.vel_x          <= next_sample.smp.vx;
                smp_ch.vel_y          <= next_sample.smp.vy;
                smp_ch.vel_z          <= next_sample.smp.vz;
            end else begin
                smp_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rec_ch.ready <= 1'b0;
            snk_gap      <= 0;
        end else if (snk_gap != 0) begin
            rec_ch.ready <= 1'b0;
            snk_gap      <= snk_gap - 1;
        end else if (snk_idle_pct != 0 && $urandom_range(0, 99) < snk_idle_pct) begin
            rec_ch.ready <= 1'b0;
            snk_gap      <= int'($urandom_range(0, 3));
        end else begin
            rec_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : observe
        t_mol_sample seen;
        t_record     got;
        t_record     want;
        if (i_rst_n) begin
            if (smp_ch.valid && smp_ch.ready) begin
                seen.mol       = smp_ch.molecule_index;
                seen.first     = smp_ch.first_frame;
                seen.species   = smp_ch.species;
                seen.smp.frame = smp_ch.frame_number;
                seen.smp.px    = smp_ch.pos_x;
                seen.smp.py    = smp_ch.pos_y;
                seen.smp.pz    = smp_ch.pos_z;
                seen.smp.vx    = smp_ch.vel_x;
                seen.smp.vy    = smp_ch.vel_y;
                seen.smp.vz    = smp_ch.vel_z;
                track_sample(seen);
                samples_taken++;
            end
            if (rec_ch.valid && rec_ch.ready) begin
                got.molecule  = rec_ch.record_molecule;
                got.smp.frame = rec_ch.record_frame;
                got.smp.px    = rec_ch.record_x;
                got.smp.py    = rec_ch.record_y;
                got.smp.pz    = rec_ch.record_z;
                got.smp.vx    = rec_ch.record_vx;
                got.smp.vy    = rec_ch.record_vy;
                got.smp.vz    = rec_ch.record_vz;
                got.is_exit   = rec_ch.is_exit_record;
                got.wall_side = rec_ch.wall_side;
                got.mcount    = rec_ch.molecule_collision_count;
                got.tcount    = rec_ch.total_collision_count;
                if (collision_records_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected record: %s", rec_text(got));
                end else begin
                    want = collision_records_due.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("record mismatch at %0t", $realtime);
                            $display("  expected %s", rec_text(want));
                            $display("  actual   %s", rec_text(got));
                        end
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (smp_ch.valid && smp_ch.ready) || (rec_ch.valid && rec_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int k;
        i_rst_n               = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_idx             = CFG_WALL_CUTOFF;
        i_cfg_data            = '0;
        smp_ch.valid          = 1'b0;
        smp_ch.molecule_index = '0;
        smp_ch.frame_number   = '0;
        smp_ch.first_frame    = 1'b0;
        smp_ch.species        = '0;
        smp_ch.pos_x          = '0;
        smp_ch.pos_y          = '0;
        smp_ch.pos_z          = '0;
        smp_ch.vel_x          = '0;
        smp_ch.vel_y          = '0;
        smp_ch.vel_z          = '0;
        rec_ch.ready          = 1'b0;
        quiet_cycles          = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: the middle band is 15360 to 87040.
        queue_sample(12'd0, 32'd0, 1'b1, 8'd1, 20'd50000, 20'd0, 20'd0,
                     20'h80000, 20'h80000, 20'h80000);
        queue_sample(12'd0, 32'd1, 1'b0, 8'd1, 20'd15359, 20'hFFFFF, 20'hFFFFF,
                     20'h7FFFF, 20'h7FFFF, 20'h7FFFF);
        queue_motion(12'd0, 32'd2, 1'b0, 8'd1, 20'd15360);
        queue_motion(12'd4095, 32'hFFFF_FFF0, 1'b1, 8'd1, 20'd87040);
        queue_motion(12'd4095, 32'd100, 1'b0, 8'd1, 20'd87041);
        queue_motion(12'd4095, 32'd101, 1'b0, 8'd1, 20'hFFFFF);
        queue_motion(12'd4095, 32'd102, 1'b0, 8'd0, 20'd50000);
        queue_motion(12'd4095, 32'hFFFF_FFFF, 1'b0, 8'd1, 20'd50000);
        queue_motion(12'd5, 32'd10, 1'b1, 8'd1, 20'd0);
        queue_motion(12'd5, 32'd11, 1'b0, 8'd1, 20'd50000);
        queue_motion(12'd5, 32'd12, 1'b0, 8'd1, 20'hFFFFF);
        queue_motion(12'd5, 32'd13, 1'b1, 8'd1, 20'd50000);
        queue_motion(12'd5, 32'd14, 1'b0, 8'd1, 20'd52400);
        queue_motion(12'd7, 32'd20, 1'b1, 8'd255, 20'd50000);
        queue_motion(12'd0, 32'd3, 1'b0, 8'd1, 20'd100000);
        queue_motion(12'd0, 32'd4, 1'b0, 8'd1, 20'd20000);
        queue_motion(12'd0, 32'd5, 1'b1, 8'd1, 20'd0);
        drain_and_settle();

        set_config(20'd0, 20'd500000, 8'd0);
        run_random_phase(200);

        src_idle_pct = 0;
        snk_idle_pct = 0;
        set_config(20'hFFFFF, 20'hFFFFF, 8'd255);
        run_random_phase(80);

        src_idle_pct = 25;
        snk_idle_pct = 25;
        set_config(20'd1000, 20'hFFFFF, 8'h5A);
        run_random_phase(200);

        set_config(20'd0, 20'd0, 8'd1);
        run_random_phase(80);

        set_config(20'd524287, 20'd1048574, 8'd3);
        run_random_phase(150);

        for (k = 0; k < 3; k++) begin
            src_idle_pct = (k == 1) ? 0 : 20;
            snk_idle_pct = (k == 2) ? 0 : 30;
            begin
                logic [19:0] c;
                c = 20'($urandom_range(0, 200000));
                set_config(c, 20'(2 * c + $urandom_range(0, 300000)),
                           8'($urandom_range(0, 255)));
            end
            run_random_phase(250);
        end

        src_idle_pct = 0;
        snk_idle_pct = 0;
        set_config(20'd15360, 20'd102400, 8'd1);
        run_random_phase(250);

        if (mismatches == 0 && collision_records_due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
